>>> rtl/core/ptd_pkg.sv
package ptd_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ID     = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_BAD_PERIOD = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  task_id;
        logic [2:0]  new_task_id;
        logic [7:0]  priority_req;
        logic [15:0] period;
    } t_in_item;

    typedef struct packed {
        logic       is_dispatch;
        logic [2:0] task_id_res;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic do_tick;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic exec_cmd;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic enable;
        logic any_due;
        logic out_free;
        logic scan_end;
        logic last_result;
    } t_stat;

endpackage

>>> rtl/core/periodic_task_dispatcher.sv
// A command is loaded in the idle state and run in the exec state once the output
// is free; the input stalls until its status item is registered. A tick updates
// the counters and dispatches each due task by a scan of the slot table, one slot
// per cycle, then an emit; it holds the input until its last item is emitted.
// Reset (synchronous, active low) empties the task table, clears all counters
// and disables the scheduler.
module periodic_task_dispatcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptd_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    ptd_pkg::t_cmd  cmd;
    ptd_pkg::t_stat stat;

    ptd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ptd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/core/ptd_ctrl.sv
module ptd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ptd_pkg::t_stat i_stat,
    output ptd_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_tick) begin
                    if (i_stat.enable) begin
                        o_cmd.do_tick = 1'b1;
                        if (i_stat.any_due) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.out_free) begin
                    o_cmd.exec_cmd = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_result) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_state == S_EMIT)
        else $error("emit outside emit state");

    a_scan_leads_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.scan_end) |=> r_state == S_EMIT)
        else $error("scan end did not reach emit");

    a_accept_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |-> !o_in_stall)
        else $error("item loaded while stalled");

endmodule

>>> rtl/core/ptd_datapath.sv
module ptd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptd_pkg::t_in_item i_in_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic              i_out_stall,
    input  ptd_pkg::t_cmd     i_cmd,
    output ptd_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output ptd_pkg::t_out_item o_out_item
);

    localparam int N = ptd_pkg::TASK_SLOTS;
    localparam int SW = ptd_pkg::SLOT_W;

    ptd_pkg::t_in_item  r_item;
    logic               r_enable;
    logic               r_valid   [N];
    logic [7:0]         r_prio    [N];
    logic [15:0]        r_period  [N];
    logic [15:0]        r_counter [N];
    logic               r_due     [N];
    logic [SW-1:0]      r_idx;
    logic [SW-1:0]      r_best;
    logic [7:0]         r_best_prio;
    logic               r_best_found;
    logic [ptd_pkg::CNT_W-1:0] r_cnt;
    logic [ptd_pkg::RES_W-1:0] r_nres;
    logic               r_out_valid;
    ptd_pkg::t_out_item r_out;

    logic [15:0]   n_inc [N];
    logic          n_due [N];
    logic          any_due;
    logic          cand;
    logic          out_free;
    logic          last_result;
    logic          id_ok;
    logic          nid_ok;
    logic [SW-1:0] id_idx;
    logic [SW-1:0] nid_idx;
    logic          v_id;
    logic          v_nid;
    logic [2:0]    cmd_st;

    always_comb begin
        any_due = 1'b0;
        for (int i = 0; i < N; i++) begin
            n_inc[i] = r_counter[i] + 16'd1;
            n_due[i] = r_valid[i] && (n_inc[i] == r_period[i]);
            any_due  = any_due | n_due[i];
        end
    end

    assign cand = r_due[r_idx] && (!r_best_found || (r_prio[r_idx] > r_best_prio));
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_result = (r_cnt == ptd_pkg::CNT_W'(1))
        || (r_nres == ptd_pkg::RES_W'(ptd_pkg::MAX_RESULTS - 1));

    assign id_ok   = 32'(r_item.task_id) < N;
    assign nid_ok  = 32'(r_item.new_task_id) < N;
    assign id_idx  = SW'(r_item.task_id);
    assign nid_idx = SW'(r_item.new_task_id);
    assign v_id    = r_valid[id_idx];
    assign v_nid   = r_valid[nid_idx];

    always_comb begin
        cmd_st = ptd_pkg::ST_OK;
        unique case (r_item.opcode)
            ptd_pkg::OP_CREATE: begin
                if (!id_ok) begin
                    cmd_st = ptd_pkg::ST_BAD_ID;
                end else if (v_id) begin
                    cmd_st = ptd_pkg::ST_BUSY;
                end else if (r_item.period == 16'd0) begin
                    cmd_st = ptd_pkg::ST_BAD_PERIOD;
                end
            end
            ptd_pkg::OP_MODIFY: begin
                if (!id_ok || !nid_ok) begin
                    cmd_st = ptd_pkg::ST_BAD_ID;
                end else if (!v_id) begin
                    cmd_st = ptd_pkg::ST_NOT_FOUND;
                end else if ((r_item.new_task_id != r_item.task_id) && v_nid) begin
                    cmd_st = ptd_pkg::ST_BUSY;
                end else if (r_item.period == 16'd0) begin
                    cmd_st = ptd_pkg::ST_BAD_PERIOD;
                end
            end
            ptd_pkg::OP_DELETE: begin
                if (!id_ok) begin
                    cmd_st = ptd_pkg::ST_BAD_ID;
                end else if (!v_id) begin
                    cmd_st = ptd_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                cmd_st = ptd_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec_cmd && cmd_st == ptd_pkg::ST_OK) begin
            if (r_item.opcode == ptd_pkg::OP_CREATE) begin
                r_prio[id_idx]   <= r_item.priority_req;
                r_period[id_idx] <= r_item.period;
            end else if (r_item.opcode == ptd_pkg::OP_MODIFY) begin
                r_prio[nid_idx]   <= r_item.priority_req;
                r_period[nid_idx] <= r_item.period;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_valid[i]   <= 1'b0;
                r_counter[i] <= 16'd0;
                r_due[i]     <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if (i_cmd.do_tick) begin
                for (int i = 0; i < N; i++) begin
                    r_due[i] <= n_due[i];
                    if (r_valid[i]) begin
                        r_counter[i] <= n_inc[i];
                    end
                end
            end
            if (i_cmd.emit) begin
                r_due[r_best]     <= 1'b0;
                r_counter[r_best] <= 16'd0;
            end
            if (i_cmd.exec_cmd && cmd_st == ptd_pkg::ST_OK) begin
                if (r_item.opcode == ptd_pkg::OP_CREATE) begin
                    r_valid[id_idx]   <= 1'b1;
                    r_counter[id_idx] <= 16'd0;
                end else if (r_item.opcode == ptd_pkg::OP_MODIFY) begin
                    if (nid_idx != id_idx) begin
                        r_valid[id_idx]   <= 1'b0;
                        r_counter[id_idx] <= 16'd0;
                    end
                    r_valid[nid_idx]   <= 1'b1;
                    r_counter[nid_idx] <= 16'd0;
                end else if (r_item.opcode == ptd_pkg::OP_DELETE) begin
                    r_valid[id_idx]   <= 1'b0;
                    r_counter[id_idx] <= 16'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_nres       <= '0;
        end else begin
            if (i_cmd.do_tick) begin
                r_nres <= '0;
            end else if (i_cmd.emit) begin
                r_nres <= r_nres + ptd_pkg::RES_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
                r_cnt        <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + SW'(1);
                if (r_due[r_idx]) begin
                    r_cnt <= r_cnt + ptd_pkg::CNT_W'(1);
                end
                if (cand) begin
                    r_best_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && cand) begin
            r_best      <= r_idx;
            r_best_prio <= r_prio[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.exec_cmd) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.is_dispatch <= 1'b1;
            r_out.task_id_res <= 3'(r_best);
            r_out.status      <= ptd_pkg::ST_OK;
            r_out.last        <= last_result;
        end else if (i_cmd.exec_cmd) begin
            r_out.is_dispatch <= 1'b0;
            r_out.task_id_res <= r_item.task_id;
            r_out.status      <= cmd_st;
            r_out.last        <= 1'b1;
        end
    end

    assign o_stat.is_tick     = (r_item.opcode == ptd_pkg::OP_TICK);
    assign o_stat.enable      = r_enable;
    assign o_stat.any_due     = any_due;
    assign o_stat.out_free    = out_free;
    assign o_stat.scan_end    = (r_idx == SW'(N - 1));
    assign o_stat.last_result = last_result;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_emit_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_best_found && r_due[r_best])
        else $error("dispatch without a due task");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_counter[$past(r_best)] == 16'd0 && !r_due[$past(r_best)])
        else $error("dispatched task not cleared");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= ptd_pkg::RES_W'(ptd_pkg::MAX_RESULTS))
        else $error("too many dispatch results");

endmodule
